>>> rtl/bcs_pkg.sv
// Shared types and constants for the battery charge sequencer.
// Used by bcs_sample, bcs_step and battery_charge_sequencer_top; no dependencies.
`timescale 1ns / 1ps

package bcs_pkg;

  // Tick timing
  localparam int unsigned PULSE_ON_TICKS    = 2;
  localparam int unsigned HALF_PERIOD_TICKS = 25;

  localparam int unsigned TICK_W  = 6;
  localparam int unsigned RUN_W   = 4;
  localparam int unsigned VOLT_W  = 14;
  localparam int unsigned MIN_W   = 8;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 14;

  localparam logic [TICK_W-1:0] PULSE_TICKS = TICK_W'(PULSE_ON_TICKS);
  localparam logic [TICK_W-1:0] HALF_TICKS  = TICK_W'(HALF_PERIOD_TICKS);
  localparam logic [TICK_W-1:0] LAST_TICK   = TICK_W'(HALF_PERIOD_TICKS - 1);
  localparam logic [RUN_W-1:0]  RUN_MAX     = '1;

  // Phase codes (code 3 is unused and behaves as idle)
  localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
  localparam logic [PHASE_W-1:0] PH_TRICKLE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_FAST    = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRICKLE_MIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_MIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT      = 3'd4;

  // Register reset values
  localparam logic [VOLT_W-1:0] RST_FULL_THRESHOLD = 14'd9500;
  localparam logic [MIN_W-1:0]  RST_TRICKLE_MIN    = 8'd5;
  localparam logic [MIN_W-1:0]  RST_FAST_MIN       = 8'd55;
  localparam logic [RUN_W-1:0]  RST_HIGH_LIMIT     = 4'd3;
  localparam logic [RUN_W-1:0]  RST_LOW_LIMIT      = 4'd7;

  typedef struct packed {
    logic              start_req;
    logic [MIN_W-1:0]  minutes;
    logic [VOLT_W-1:0] volt_mv;
  } in_item_t;

  typedef struct packed {
    logic               charge_on;
    logic               green_led;
    logic               red_led;
    logic [PHASE_W-1:0] phase;
    logic               battery_full;
    logic               cycle_done;
  } out_item_t;

  typedef struct packed {
    logic [VOLT_W-1:0] full_threshold_mv;
    logic [MIN_W-1:0]  trickle_minutes;
    logic [MIN_W-1:0]  fast_minutes;
    logic [RUN_W-1:0]  high_count_limit;
    logic [RUN_W-1:0]  low_count_limit;
  } cfg_t;

  // Sequencer state; charge/green/red are the drive bits
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [TICK_W-1:0]  tick;
    logic               blink;
    logic               full;
    logic [RUN_W-1:0]   low_run;
    logic [RUN_W-1:0]   high_run;
    logic               charge;
    logic               green;
    logic               red;
  } seq_state_t;

  // Full-detector state
  typedef struct packed {
    logic             full;
    logic [RUN_W-1:0] low_run;
    logic [RUN_W-1:0] high_run;
  } det_state_t;

endpackage

>>> rtl/bcs_sample.sv
// Full detector: one voltage sample against the threshold, run counters and flag.
// Depends on bcs_pkg.
`timescale 1ns / 1ps

module bcs_sample (
  input  bcs_pkg::det_state_t       cur,
  input  logic [bcs_pkg::VOLT_W-1:0] volt_mv,
  input  bcs_pkg::cfg_t             cfg,
  output bcs_pkg::det_state_t       upd
);

  logic above;

  assign above = volt_mv > cfg.full_threshold_mv;

  always_comb begin
    upd = cur;
    if (cur.full) begin
      if (above) begin
        upd.low_run = '0;
      end else if (cur.low_run != bcs_pkg::RUN_MAX) begin
        upd.low_run = cur.low_run + 4'd1;
      end
      if (upd.low_run > cfg.low_count_limit) begin
        upd.full    = 1'b0;
        upd.low_run = '0;
      end
    end else begin
      if (above) begin
        upd.low_run = '0;
        if (cur.high_run != bcs_pkg::RUN_MAX) begin
          upd.high_run = cur.high_run + 4'd1;
        end
      end else begin
        upd.high_run = '0;
      end
      if (upd.high_run > cfg.high_count_limit) begin
        upd.full     = 1'b1;
        upd.high_run = '0;
      end
    end
  end

endmodule

>>> rtl/bcs_step.sv
// Next-state and result logic for one tick: start, trickle and fast phases.
// Depends on bcs_pkg and bcs_sample.
`timescale 1ns / 1ps

module bcs_step (
  input  bcs_pkg::seq_state_t cur,
  input  bcs_pkg::in_item_t   item,
  input  bcs_pkg::cfg_t       cfg,
  output bcs_pkg::seq_state_t nxt,
  output bcs_pkg::out_item_t  res
);

  bcs_pkg::seq_state_t st0;
  bcs_pkg::det_state_t det_cur;
  bcs_pkg::det_state_t det_upd;

  // Idle handling and start
  always_comb begin
    st0 = cur;
    if (cur.phase != bcs_pkg::PH_TRICKLE && cur.phase != bcs_pkg::PH_FAST) begin
      st0.phase = bcs_pkg::PH_IDLE;
      if (item.start_req) begin
        st0.full   = 1'b0;
        st0.charge = 1'b0;
        st0.green  = 1'b0;
        st0.red    = 1'b0;
        st0.phase  = bcs_pkg::PH_TRICKLE;
        st0.tick   = '0;
        st0.blink  = 1'b0;
      end
    end
  end

  // At most one sample per tick, always taken on the post-start state
  assign det_cur = '{full: st0.full, low_run: st0.low_run, high_run: st0.high_run};

  bcs_sample u_sample (
    .cur     (det_cur),
    .volt_mv (item.volt_mv),
    .cfg     (cfg),
    .upd     (det_upd)
  );

  always_comb begin
    logic go_fast;
    logic done;
    go_fast = 1'b0;
    done    = 1'b0;
    nxt     = st0;

    if (st0.phase == bcs_pkg::PH_TRICKLE) begin
      if (!st0.blink && st0.tick == '0) begin
        if (item.minutes >= cfg.trickle_minutes) begin
          go_fast = 1'b1;
        end else begin
          nxt.green    = 1'b1;
          nxt.full     = det_upd.full;
          nxt.low_run  = det_upd.low_run;
          nxt.high_run = det_upd.high_run;
          if (!det_upd.full) begin
            go_fast = 1'b1;
          end
        end
      end
      if (go_fast) begin
        nxt.phase  = bcs_pkg::PH_FAST;
        nxt.tick   = '0;
        nxt.blink  = 1'b0;
        nxt.red    = 1'b1;
        nxt.charge = 1'b1;
      end else begin
        nxt.charge = !st0.blink && (st0.tick < bcs_pkg::PULSE_TICKS);
        nxt.green  = !st0.blink;
        if (st0.blink && st0.tick == '0) begin
          nxt.full     = det_upd.full;
          nxt.low_run  = det_upd.low_run;
          nxt.high_run = det_upd.high_run;
        end
        nxt.tick = st0.tick + 6'd1;
        if (nxt.tick >= bcs_pkg::HALF_TICKS) begin
          nxt.tick  = '0;
          nxt.blink = !st0.blink;
        end
      end
    end

    // Fast phase; may follow a trickle exit in the same tick (tick is then zero)
    if (nxt.phase == bcs_pkg::PH_FAST) begin
      if (nxt.tick == '0) begin
        if (item.minutes >= cfg.fast_minutes || nxt.full) begin
          nxt.charge = 1'b0;
          nxt.phase  = bcs_pkg::PH_IDLE;
          nxt.blink  = 1'b0;
          done       = 1'b1;
        end else begin
          nxt.green = nxt.blink;
          nxt.blink = !nxt.blink;
        end
      end
      if (!done) begin
        // a sample here needs the last tick of a half, so the phase was already fast
        if (nxt.tick >= bcs_pkg::LAST_TICK) begin
          nxt.full     = det_upd.full;
          nxt.low_run  = det_upd.low_run;
          nxt.high_run = det_upd.high_run;
        end
        nxt.tick = nxt.tick + 6'd1;
        if (nxt.tick >= bcs_pkg::HALF_TICKS) begin
          nxt.tick = '0;
        end
      end
    end

    res.charge_on    = nxt.charge;
    res.green_led    = nxt.green;
    res.red_led      = nxt.red;
    res.phase        = nxt.phase;
    res.battery_full = nxt.full;
    res.cycle_done   = done;
  end

endmodule

>>> rtl/battery_charge_sequencer_top.sv
// Top level of the battery charge sequencer: handshakes, registers and state.
// Depends on bcs_pkg and bcs_step (which uses bcs_sample).
`timescale 1ns / 1ps

// Usage
//   Input channel in_valid/in_stall/in_data: one transfer per 20 ms tick, carrying
//   start_req, elapsed minutes and a voltage sample in mV.
//   Output channel out_valid/out_stall/out_data: exactly one result per tick
//   (drive bits, LEDs, phase, full flag and the end-of-cycle marker), in order.
//   Config channel cfg_valid/cfg_ready/cfg_index/cfg_data: writes one of the five
//   registers; cfg_ready is always high. Write only while the block is idle.
// Timing
//   The tick is captured in an input register, and the whole step is one pass of
//   combinational logic into the result register.
//   Throughput is one tick per cycle unless out_stall holds the result register.
// Reset (rst, synchronous): phase idle, all drive bits off, counters and full
//   flag cleared, registers back to their defaults, both stages empty.
// Stall: a stalled result holds in the output register; the input register
//   still moves into it when it is taken, so in_stall rises only when both
//   stages are full and out_stall is high.

module battery_charge_sequencer_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bcs_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bcs_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  bcs_pkg::cfg_t       cfg;
  bcs_pkg::seq_state_t state;
  bcs_pkg::seq_state_t state_next;
  bcs_pkg::in_item_t   in_reg;
  bcs_pkg::out_item_t  res_next;
  logic                in_reg_valid;
  logic                advance;

  assign cfg_ready = 1'b1;

  // Stage moves on whenever the result register is free or being emptied
  assign advance  = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_threshold_mv <= bcs_pkg::RST_FULL_THRESHOLD;
      cfg.trickle_minutes   <= bcs_pkg::RST_TRICKLE_MIN;
      cfg.fast_minutes      <= bcs_pkg::RST_FAST_MIN;
      cfg.high_count_limit  <= bcs_pkg::RST_HIGH_LIMIT;
      cfg.low_count_limit   <= bcs_pkg::RST_LOW_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bcs_pkg::CFG_FULL_THRESHOLD: cfg.full_threshold_mv <= cfg_data;
        bcs_pkg::CFG_TRICKLE_MIN:    cfg.trickle_minutes   <= cfg_data[bcs_pkg::MIN_W-1:0];
        bcs_pkg::CFG_FAST_MIN:       cfg.fast_minutes      <= cfg_data[bcs_pkg::MIN_W-1:0];
        bcs_pkg::CFG_HIGH_LIMIT:     cfg.high_count_limit  <= cfg_data[bcs_pkg::RUN_W-1:0];
        bcs_pkg::CFG_LOW_LIMIT:      cfg.low_count_limit   <= cfg_data[bcs_pkg::RUN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_reg <= in_data;
    end
  end

  bcs_step u_step (
    .cur  (state),
    .item (in_reg),
    .cfg  (cfg),
    .nxt  (state_next),
    .res  (res_next)
  );

  // Sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_data <= res_next;
    end
  end

endmodule

>>> bench/battery_charge_sequencer_top_tb.sv
// Self-checking bench for battery_charge_sequencer_top: directed ticks, then random charge cycles
// under several register settings. Depends on bcs_pkg and the RTL under rtl/ only.
`timescale 1ns / 1ps

// Tracks the expected sequencer state and checks every result transfer in order.
class charge_scoreboard;
  bcs_pkg::cfg_t       regs;
  bcs_pkg::seq_state_t st;
  bcs_pkg::out_item_t  pending_outputs[$];
  int unsigned errors, n_checked, n_trickle, n_fast, n_done, n_full;

  function new();
    regs = '{full_threshold_mv: bcs_pkg::RST_FULL_THRESHOLD,
             trickle_minutes: bcs_pkg::RST_TRICKLE_MIN,
             fast_minutes: bcs_pkg::RST_FAST_MIN,
             high_count_limit: bcs_pkg::RST_HIGH_LIMIT,
             low_count_limit: bcs_pkg::RST_LOW_LIMIT};
    st = '0;
    st.phase = bcs_pkg::PH_IDLE;
  endfunction

  function void write_reg(logic [bcs_pkg::CFG_IDX_W-1:0] idx,
                          logic [bcs_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      bcs_pkg::CFG_FULL_THRESHOLD: regs.full_threshold_mv = val[bcs_pkg::VOLT_W-1:0];
      bcs_pkg::CFG_TRICKLE_MIN:    regs.trickle_minutes   = val[bcs_pkg::MIN_W-1:0];
      bcs_pkg::CFG_FAST_MIN:       regs.fast_minutes      = val[bcs_pkg::MIN_W-1:0];
      bcs_pkg::CFG_HIGH_LIMIT:     regs.high_count_limit  = val[bcs_pkg::RUN_W-1:0];
      bcs_pkg::CFG_LOW_LIMIT:      regs.low_count_limit   = val[bcs_pkg::RUN_W-1:0];
      default: ;
    endcase
  endfunction

  // Consecutive-sample qualification of the full flag
  function void take_sample(logic [bcs_pkg::VOLT_W-1:0] v);
    logic above;
    above = v > regs.full_threshold_mv;
    if (st.full) begin
      if (above) st.low_run = '0;
      else if (st.low_run != bcs_pkg::RUN_MAX) st.low_run = st.low_run + 4'd1;
      if (st.low_run > regs.low_count_limit) begin
        st.full    = 1'b0;
        st.low_run = '0;
      end
    end else begin
      if (above) begin
        st.low_run = '0;
        if (st.high_run != bcs_pkg::RUN_MAX) st.high_run = st.high_run + 4'd1;
      end else begin
        st.high_run = '0;
      end
      if (st.high_run > regs.high_count_limit) begin
        st.full     = 1'b1;
        st.high_run = '0;
      end
    end
  endfunction

  // One 20 ms tick; pushes the result it should give
  function void note_tick(bcs_pkg::in_item_t x);
    logic               leave;
    logic               done;
    bcs_pkg::out_item_t res;
    done  = 1'b0;
    leave = 1'b0;
    if (st.phase != bcs_pkg::PH_TRICKLE && st.phase != bcs_pkg::PH_FAST) begin
      st.phase = bcs_pkg::PH_IDLE;
      if (x.start_req) begin
        st.full   = 1'b0;
        st.charge = 1'b0;
        st.green  = 1'b0;
        st.red    = 1'b0;
        st.phase  = bcs_pkg::PH_TRICKLE;
        st.tick   = '0;
        st.blink  = 1'b0;
      end
    end
    if (st.phase == bcs_pkg::PH_TRICKLE) begin
      if (!st.blink && st.tick == '0) begin
        if (x.minutes >= regs.trickle_minutes) begin
          leave = 1'b1;
        end else begin
          st.green = 1'b1;
          take_sample(x.volt_mv);
          leave = !st.full;
        end
      end
      if (leave) begin
        st.phase  = bcs_pkg::PH_FAST;
        st.tick   = '0;
        st.blink  = 1'b0;
        st.red    = 1'b1;
        st.charge = 1'b1;
      end else begin
        st.charge = !st.blink && (st.tick < bcs_pkg::PULSE_TICKS);
        st.green  = !st.blink;
        if (st.blink && st.tick == '0) take_sample(x.volt_mv);
        st.tick = st.tick + 6'd1;
        if (st.tick >= bcs_pkg::HALF_TICKS) begin
          st.tick  = '0;
          st.blink = !st.blink;
        end
      end
    end
    if (st.phase == bcs_pkg::PH_FAST) begin
      if (st.tick == '0 && (x.minutes >= regs.fast_minutes || st.full)) begin
        st.charge = 1'b0;
        st.phase  = bcs_pkg::PH_IDLE;
        st.tick   = '0;
        st.blink  = 1'b0;
        done      = 1'b1;
      end else begin
        if (st.tick == '0) begin
          st.green = st.blink;
          st.blink = !st.blink;
        end
        if (st.tick >= bcs_pkg::LAST_TICK) take_sample(x.volt_mv);
        st.tick = st.tick + 6'd1;
        if (st.tick >= bcs_pkg::HALF_TICKS) st.tick = '0;
      end
    end
    res.charge_on    = st.charge;
    res.green_led    = st.green;
    res.red_led      = st.red;
    res.phase        = st.phase;
    res.battery_full = st.full;
    res.cycle_done   = done;
    pending_outputs.push_back(res);
    if (st.phase == bcs_pkg::PH_TRICKLE) n_trickle++;
    if (st.phase == bcs_pkg::PH_FAST) n_fast++;
    if (done) n_done++;
    if (st.full) n_full++;
  endfunction

  function void cmp(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(bcs_pkg::out_item_t got);
    bcs_pkg::out_item_t want;
    if (pending_outputs.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = pending_outputs.pop_front();
    n_checked++;
    cmp("charge_on", 32'(want.charge_on), 32'(got.charge_on));
    cmp("green_led", 32'(want.green_led), 32'(got.green_led));
    cmp("red_led", 32'(want.red_led), 32'(got.red_led));
    cmp("phase", 32'(want.phase), 32'(got.phase));
    cmp("battery_full", 32'(want.battery_full), 32'(got.battery_full));
    cmp("cycle_done", 32'(want.cycle_done), 32'(got.cycle_done));
  endfunction

  function int unsigned pending();
    return pending_outputs.size();
  endfunction
endclass

module battery_charge_sequencer_top_tb;

  localparam int unsigned VOLT_MAX       = (1 << bcs_pkg::VOLT_W) - 1;
  localparam int unsigned MIN_MAX        = (1 << bcs_pkg::MIN_W) - 1;
  localparam int unsigned GAP_MAX        = 5;
  localparam int unsigned HOLD_CYCLES    = 80;   // long receiver hold-off, fills both stages
  localparam int unsigned SETTLE_CYCLES  = 6;    // two-stage pipe plus margin
  localparam int unsigned WATCHDOG_LIMIT = 1000; // well above the hold-off and any gap
  localparam int unsigned N_PHASES       = 6;
  localparam int unsigned PHASE_TICKS    = 100;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  bcs_pkg::in_item_t   in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  bcs_pkg::out_item_t  out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [bcs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bcs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  charge_scoreboard sb;
  logic        running  = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned tx_max_gap = GAP_MAX;
  int unsigned rx_max_gap = GAP_MAX;
  int unsigned n_sent = 0;
  int unsigned n_settings = 0;
  int unsigned quiet_cycles = 0;

  battery_charge_sequencer_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bcs_pkg::in_item_t mk_tick(int unsigned s, int unsigned m,
                                                int unsigned v);
    bcs_pkg::in_item_t t;
    t.start_req = 1'(s);
    t.minutes   = bcs_pkg::MIN_W'(m);
    t.volt_mv   = bcs_pkg::VOLT_W'(v);
    return t;
  endfunction

  function automatic bcs_pkg::cfg_t make_cfg(int unsigned thr, int unsigned tr,
                                             int unsigned fa, int unsigned hi,
                                             int unsigned lo);
    bcs_pkg::cfg_t c;
    c.full_threshold_mv = bcs_pkg::VOLT_W'(thr);
    c.trickle_minutes   = bcs_pkg::MIN_W'(tr);
    c.fast_minutes      = bcs_pkg::MIN_W'(fa);
    c.high_count_limit  = bcs_pkg::RUN_W'(hi);
    c.low_count_limit   = bcs_pkg::RUN_W'(lo);
    return c;
  endfunction

  // One tick transfer on the input channel, after a random gap with valid low.
  // Valid is left high on return so a back-to-back tick needs no second assignment.
  task automatic send_tick(bcs_pkg::in_item_t tk);
    int unsigned gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= tk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(tk);
    n_sent++;
  endtask

  // Drop valid and wait until every expected result has been taken, then a few
  // more cycles so the pipe is empty for a register write.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_one(logic [bcs_pkg::CFG_IDX_W-1:0] idx,
                           logic [bcs_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // All five registers, back to back; valid drops once at the end
  task automatic apply_config(bcs_pkg::cfg_t c);
    write_one(bcs_pkg::CFG_FULL_THRESHOLD, bcs_pkg::CFG_DATA_W'(c.full_threshold_mv));
    write_one(bcs_pkg::CFG_TRICKLE_MIN, bcs_pkg::CFG_DATA_W'(c.trickle_minutes));
    write_one(bcs_pkg::CFG_FAST_MIN, bcs_pkg::CFG_DATA_W'(c.fast_minutes));
    write_one(bcs_pkg::CFG_HIGH_LIMIT, bcs_pkg::CFG_DATA_W'(c.high_count_limit));
    write_one(bcs_pkg::CFG_LOW_LIMIT, bcs_pkg::CFG_DATA_W'(c.low_count_limit));
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Result side: random stall before each transfer, plus one long hold-off on request
  initial begin : result_sink
    int unsigned wait_cycles;
    wait (running);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      wait_cycles = $urandom_range(0, rx_max_gap);
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_data);
    end
  end

  // Watchdog: any transfer on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, sb.pending());
      $display("battery_charge_sequencer_top_tb: errors");
      $finish;
    end
  end

  initial begin : stimulus
    bcs_pkg::cfg_t     c;
    bcs_pkg::in_item_t tk;
    int unsigned phase_start, len, pct, step, thr, k;
    logic [bcs_pkg::MIN_W-1:0] mins;
    logic        above, paused;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    running = 1'b1;

    // Directed: defaults after reset. Idle ticks at the field extremes, then a
    // start whose single high sample cannot qualify, so it goes straight to fast.
    send_tick(mk_tick(0, 0, 0));
    send_tick(mk_tick(0, MIN_MAX, VOLT_MAX));
    send_tick(mk_tick(1, 0, VOLT_MAX));
    send_tick(mk_tick(1, 0, 0));            // start while busy is ignored
    send_tick(mk_tick(0, MIN_MAX, 0));
    send_tick(mk_tick(0, 0, VOLT_MAX));
    settle();

    // Both minute limits at zero: trickle ends by time and fast ends on the start tick
    apply_config(make_cfg(0, 0, 0, 0, 0));
    send_tick(mk_tick(1, 0, 1));
    send_tick(mk_tick(0, 0, 0));
    settle();

    // Top threshold: no sample can be above it; limits of 15 never qualify
    apply_config(make_cfg(VOLT_MAX, MIN_MAX, 0, 15, 15));
    send_tick(mk_tick(1, 0, VOLT_MAX));
    send_tick(mk_tick(1, 0, VOLT_MAX));
    settle();

    // One high sample qualifies: trickle runs, charge pulse then off, starts ignored
    apply_config(make_cfg(100, MIN_MAX, MIN_MAX, 0, 0));
    send_tick(mk_tick(1, 0, 101));
    send_tick(mk_tick(0, 0, 100));
    send_tick(mk_tick(1, 1, 0));
    send_tick(mk_tick(1, MIN_MAX - 1, VOLT_MAX));
    send_tick(mk_tick(0, 2, 100));
    settle();

    // Random part: each phase has its own register setting and a run of charge
    // cycles. A cycle opens with a start, minutes climb at a random rate and the
    // voltage sits above or below the threshold with a per-cycle bias; about one
    // tick in ten is pure noise.
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: c = make_cfg(8000, 12, 30, 0, 2);                // deep trickle, flag clears
        1: c = make_cfg(0, MIN_MAX, MIN_MAX, 15, 15);       // extremes, never full
        2: c = make_cfg(VOLT_MAX, 0, 0, 0, 0);              // every cycle ends at once
        default: begin
          c = make_cfg($urandom_range(0, VOLT_MAX), $urandom_range(0, 20),
                       $urandom_range(0, 60), $urandom_range(0, 4), $urandom_range(0, 8));
          if ($urandom_range(0, 3) == 0)
            c.full_threshold_mv = bcs_pkg::VOLT_W'(VOLT_MAX - 1);
        end
      endcase
      apply_config(c);
      // No idling at all in one phase; the long hold-off in another
      tx_max_gap = (p == 2) ? 0 : GAP_MAX;
      rx_max_gap = (p == 2) ? 0 : GAP_MAX;
      if (p == 1) hold_req = 1'b1;
      paused = 1'b0;
      phase_start = n_sent;
      while (n_sent - phase_start < PHASE_TICKS) begin
        len = ($urandom_range(0, 2) == 0) ? $urandom_range(4, 30) : $urandom_range(30, 160);
        if (len > PHASE_TICKS - (n_sent - phase_start))
          len = PHASE_TICKS - (n_sent - phase_start);
        case ($urandom_range(0, 4))
          0: pct = 100;
          1: pct = 90;
          2: pct = 60;
          3: pct = 20;
          default: pct = 0;
        endcase
        step = $urandom_range(1, 30);
        mins = ($urandom_range(0, 3) == 0) ? bcs_pkg::MIN_W'($urandom_range(0, MIN_MAX)) : '0;
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            tk = mk_tick($urandom_range(0, 1), $urandom_range(0, MIN_MAX),
                         $urandom_range(0, VOLT_MAX));
          end else begin
            thr = 32'(sb.regs.full_threshold_mv);
            above = ($urandom_range(0, 99) < pct) && (thr < VOLT_MAX);
            tk.start_req = (k == 0) || ($urandom_range(0, 19) == 0);
            tk.minutes   = mins;
            // A quarter of samples sit right on either side of the threshold
            if (above)
              tk.volt_mv = ($urandom_range(0, 3) == 0) ?
                           bcs_pkg::VOLT_W'(thr + 1) :
                           bcs_pkg::VOLT_W'($urandom_range(thr + 1, VOLT_MAX));
            else
              tk.volt_mv = ($urandom_range(0, 3) == 0) ?
                           bcs_pkg::VOLT_W'(thr) :
                           bcs_pkg::VOLT_W'($urandom_range(0, thr));
          end
          send_tick(tk);
          if ($urandom_range(1, step) == 1 && mins != bcs_pkg::MIN_W'(MIN_MAX))
            mins = mins + 8'd1;
        end
        // Sender pause: wait for every outstanding result mid-phase
        if (p == 3 && !paused) begin
          settle();
          paused = 1'b1;
        end
      end
      settle();
    end

    settle();
    $display("covered %0d ticks under %0d register settings: %0d trickle, %0d fast, %0d ended",
             n_sent, n_settings, sb.n_trickle, sb.n_fast, sb.n_done);
    $display("%0d results checked, %0d with the full flag set, %0d mismatches",
             sb.n_checked, sb.n_full, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("battery_charge_sequencer_top_tb: clean");
    else
      $display("battery_charge_sequencer_top_tb: errors");
    $finish;
  end

endmodule

>>> filelist.f
rtl/bcs_pkg.sv
rtl/bcs_sample.sv
rtl/bcs_step.sv
rtl/battery_charge_sequencer_top.sv
bench/battery_charge_sequencer_top_tb.sv
